// File: design/pcnm_pkg.sv
// Package for the periodic cube neighbour max block.
// Opcodes, field widths and stream widths used by the front, back and top design files. No dependencies.
package pcnm_pkg;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam int POS_W      = 4;
  localparam int SAMPLE_W   = 32;
  localparam int BOUND_W    = 31;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;

  localparam logic [BOUND_W-1:0] BOUND_MAX = {BOUND_W{1'b1}};

endpackage

// File: design/pcnm_front.sv
// Front end: takes input items, wraps positions onto the grid and builds a command word.
// Uses pcnm_pkg.
module pcnm_front #(
  parameter int GRID_SIZE = 16,
  parameter int CMD_W     = 1 + 6 * $clog2(GRID_SIZE) + pcnm_pkg::SAMPLE_W
) (
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [3:0] pos_x, [7:4] pos_y, [11:8] pos_z, [43:12] sample, [47:44] zero
  input  logic [pcnm_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // [0] opcode
  input  logic                           s_axis_tuser,
  output logic                           cmd_valid,
  input  logic                           cmd_ready,
  output logic [CMD_W-1:0]               cmd_data
);

  localparam int AW = $clog2(GRID_SIZE);
  localparam int PW = pcnm_pkg::POS_W;

  logic [AW-1:0] wrap_lut [2**PW];
  logic [AW-1:0] x0, x1, y0, y1, z0, z1;
  logic [PW-1:0] raw_x, raw_y, raw_z;
  logic [pcnm_pkg::SAMPLE_W-1:0] sample;

  // raw position modulo grid size, as a constant table
  for (genvar g = 0; g < 2**PW; g++) begin : g_lut
    assign wrap_lut[g] = AW'(g % GRID_SIZE);
  end

  assign raw_x  = s_axis_tdata[PW-1:0];
  assign raw_y  = s_axis_tdata[2*PW-1:PW];
  assign raw_z  = s_axis_tdata[3*PW-1:2*PW];
  assign sample = s_axis_tdata[3*PW+pcnm_pkg::SAMPLE_W-1:3*PW];

  assign x0 = wrap_lut[raw_x];
  assign y0 = wrap_lut[raw_y];
  assign z0 = wrap_lut[raw_z];

  assign x1 = (x0 == AW'(GRID_SIZE - 1)) ? '0 : x0 + AW'(1);
  assign y1 = (y0 == AW'(GRID_SIZE - 1)) ? '0 : y0 + AW'(1);
  assign z1 = (z0 == AW'(GRID_SIZE - 1)) ? '0 : z0 + AW'(1);

  assign cmd_data      = {sample, z1, z0, y1, y0, x1, x0, s_axis_tuser};
  assign cmd_valid     = s_axis_tvalid;
  assign s_axis_tready = cmd_ready;

endmodule

// File: design/pcnm_queue.sv
// Two-entry command queue between front and back ends.
// Generic width; no package dependencies.
module pcnm_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slot[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: design/pcnm_back.sv
// Back end: grid memory, load writes and the eight-read neighbour max sequencer.
// Uses pcnm_pkg; takes commands built by pcnm_front.
module pcnm_back #(
  parameter int GRID_SIZE = 16,
  parameter int CMD_W     = 1 + 6 * $clog2(GRID_SIZE) + pcnm_pkg::SAMPLE_W
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  output logic                            cmd_ready,
  input  logic [CMD_W-1:0]                cmd_data,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [30:0] bound, [31] zero
  output logic [pcnm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int AW     = $clog2(GRID_SIZE);
  localparam int CELLS  = GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int SW     = pcnm_pkg::SAMPLE_W;
  localparam int BW     = pcnm_pkg::BOUND_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_LAST = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [SW-1:0] grid [CELLS];

  logic [1:0]        state;
  logic [2:0]        step;
  logic [AW-1:0]     qx0, qx1, qy0, qy1, qz0, qz1;
  logic [SW-1:0]     rd_data;
  logic              rd_vld;
  logic [BW-1:0]     best;
  logic [BW-1:0]     best_next;
  logic [BW-1:0]     mag;
  logic [SW-1:0]     neg;
  logic              out_valid;
  logic [BW-1:0]     out_bound;
  logic              cmd_take;
  logic              cmd_op;
  logic [AW-1:0]     cx0, cy0, cz0;
  logic [SW-1:0]     c_sample;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic              rd_en;
  logic              out_free;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [AW-1:0] x,
                                                  input logic [AW-1:0] y,
                                                  input logic [AW-1:0] z);
    cell_addr = ADDR_W'(ADDR_W'(x) * ADDR_W'(GRID_SIZE * GRID_SIZE)
                      + ADDR_W'(y) * ADDR_W'(GRID_SIZE) + ADDR_W'(z));
  endfunction

  assign cmd_op   = cmd_data[0];
  assign cx0      = cmd_data[1+AW-1:1];
  assign cy0      = cmd_data[1+3*AW-1:1+2*AW];
  assign cz0      = cmd_data[1+5*AW-1:1+4*AW];
  assign c_sample = cmd_data[1+6*AW+SW-1:1+6*AW];

  assign cmd_ready = (state == ST_IDLE);
  assign cmd_take  = cmd_valid && cmd_ready;
  assign wr_en     = cmd_take && (cmd_op == pcnm_pkg::OP_LOAD);
  assign wr_addr   = cell_addr(cx0, cy0, cz0);
  assign rd_en     = (state == ST_READ);
  // step bits pick the +1 neighbour on x, y, z
  assign rd_addr   = cell_addr(step[2] ? qx1 : qx0, step[1] ? qy1 : qy0,
                               step[0] ? qz1 : qz0);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      grid[wr_addr] <= c_sample;
    end else if (rd_en) begin
      rd_data <= grid[rd_addr];
    end
  end

  // absolute value, most negative saturates
  assign neg = ~rd_data + SW'(1);
  always_comb begin
    if (rd_data == {1'b1, {(SW-1){1'b0}}}) begin
      mag = pcnm_pkg::BOUND_MAX;
    end else if (rd_data[SW-1]) begin
      mag = neg[BW-1:0];
    end else begin
      mag = rd_data[BW-1:0];
    end
  end

  assign best_next = (rd_vld && (mag > best)) ? mag : best;
  assign out_free  = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (cmd_take && (cmd_op == pcnm_pkg::OP_QUERY)) begin
      qx0  <= cx0;
      qx1  <= cmd_data[1+2*AW-1:1+AW];
      qy0  <= cy0;
      qy1  <= cmd_data[1+4*AW-1:1+3*AW];
      qz0  <= cz0;
      qz1  <= cmd_data[1+6*AW-1:1+5*AW];
      best <= '0;
    end else begin
      best <= best_next;
    end
    if ((state == ST_OUT) && out_free) begin
      out_bound <= best;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= 3'd0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      if ((state == ST_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          step <= 3'd0;
          if (cmd_take && (cmd_op == pcnm_pkg::OP_QUERY)) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          step <= step + 3'd1;
          if (step == 3'd7) begin
            state <= ST_LAST;
          end
        end
        ST_LAST: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_bound};

endmodule

// File: design/periodic_cube_neighbour_max_top.sv
// Loads are written to the grid as the back end accepts them; queries occupy the back end
// for eight reads of the single-port grid memory, a drain step, an output load and an idle/accept.
// Front and back are split by a two-entry queue, so the input keeps flowing until the queue is full.
// rst (synchronous) clears queue and sequencer control; grid contents are not cleared.
// Top level: front end, command queue and back end. Uses pcnm_pkg.
module periodic_cube_neighbour_max_top #(
  parameter int GRID_SIZE = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [3:0] pos_x, [7:4] pos_y, [11:8] pos_z, [43:12] sample, [47:44] zero
  input  logic [pcnm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [0] opcode
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [30:0] bound, [31] zero
  output logic [pcnm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int CMD_W = 1 + 6 * $clog2(GRID_SIZE) + pcnm_pkg::SAMPLE_W;

  logic             f_valid;
  logic             f_ready;
  logic [CMD_W-1:0] f_data;
  logic             b_valid;
  logic             b_ready;
  logic [CMD_W-1:0] b_data;

  pcnm_front #(
    .GRID_SIZE (GRID_SIZE),
    .CMD_W     (CMD_W)
  ) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid     (f_valid),
    .cmd_ready     (f_ready),
    .cmd_data      (f_data)
  );

  pcnm_queue #(
    .WIDTH (CMD_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_data  (b_data)
  );

  pcnm_back #(
    .GRID_SIZE (GRID_SIZE),
    .CMD_W     (CMD_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (b_valid),
    .cmd_ready     (b_ready),
    .cmd_data      (b_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
